// ===== rtl/core/pvp_pkg.sv =====
// ----------------------------------------------------------------------------
// pvp_pkg
// shared types, constants and register indexes of the vertex projector
// ----------------------------------------------------------------------------
package pvp_pkg;

    localparam int unsigned FOCAL_SCALE_DEF = 256;
    localparam int unsigned CfgIdxW = 3;
    localparam int unsigned CfgDataW = 12;

    // width of |x * focal|: 32-bit magnitude plus up to 16 bits of focal shift
    localparam int unsigned NumW = 48;
    localparam int unsigned DenW = 31;

    typedef enum logic [CfgIdxW-1:0] {
        REG_MID_X         = 3'd0,
        REG_MID_Y         = 3'd1,
        REG_PIXEL_SCALE   = 3'd2,
        REG_WINDOW_LEFT   = 3'd3,
        REG_WINDOW_RIGHT  = 3'd4,
        REG_WINDOW_TOP    = 3'd5,
        REG_WINDOW_BOTTOM = 3'd6
    } cfg_idx_t;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
    } vertex_t;

    typedef struct packed {
        logic signed [31:0] pix_x;
        logic signed [31:0] pix_y;
        logic               in_front;
        logic               on_screen;
    } result_t;

    // one division step for both axes, handed from cell to cell
    typedef struct packed {
        logic              valid;
        logic              in_front;
        logic [NumW-1:0]   num_x;
        logic [NumW-1:0]   num_y;
        logic [NumW-1:0]   rem_x;
        logic [NumW-1:0]   rem_y;
        logic [DenW-1:0]   den;
        logic              neg_x;
        logic              neg_y;
    } div_cell_t;

endpackage

// ===== rtl/core/pvp_div_cell.sv =====
// ----------------------------------------------------------------------------
// pvp_div_cell
// one restoring division step for x and y against a shared divisor
// ----------------------------------------------------------------------------
module pvp_div_cell
(
    input  logic                clk,
    input  logic                rst_n,
    input  pvp_pkg::div_cell_t  cell_in,
    output pvp_pkg::div_cell_t  cell_out
);

    pvp_pkg::div_cell_t cell_reg;
    pvp_pkg::div_cell_t cell_next;

    logic [pvp_pkg::NumW:0] trial_x;
    logic [pvp_pkg::NumW:0] trial_y;
    logic [pvp_pkg::NumW:0] den_ext;

    always_comb
    begin
        cell_next = cell_in;
        den_ext   = {{(pvp_pkg::NumW + 1 - pvp_pkg::DenW){1'b0}}, cell_in.den};
        // shift the next numerator bit into the partial remainder
        trial_x = {cell_in.rem_x, cell_in.num_x[pvp_pkg::NumW-1]};
        trial_y = {cell_in.rem_y, cell_in.num_y[pvp_pkg::NumW-1]};
        cell_next.num_x = {cell_in.num_x[pvp_pkg::NumW-2:0], 1'b0};
        cell_next.num_y = {cell_in.num_y[pvp_pkg::NumW-2:0], 1'b0};
        if (trial_x >= den_ext)
        begin
            cell_next.rem_x = pvp_pkg::NumW'(trial_x - den_ext);
            cell_next.num_x[0] = 1'b1;
        end
        else
        begin
            cell_next.rem_x = trial_x[pvp_pkg::NumW-1:0];
        end
        if (trial_y >= den_ext)
        begin
            cell_next.rem_y = pvp_pkg::NumW'(trial_y - den_ext);
            cell_next.num_y[0] = 1'b1;
        end
        else
        begin
            cell_next.rem_y = trial_y[pvp_pkg::NumW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_reg <= '0;
        end
        else
        begin
            cell_reg <= cell_next;
        end
    end

    assign cell_out = cell_reg;

endmodule

// ===== rtl/core/pvp_finish.sv =====
// ----------------------------------------------------------------------------
// pvp_finish
// sign fix, scale, centre offset, saturation and window test
// ----------------------------------------------------------------------------
module pvp_finish
(
    input  logic                clk,
    input  logic                rst_n,
    input  pvp_pkg::div_cell_t  cell_in,
    input  logic [11:0]         mid_x,
    input  logic [11:0]         mid_y,
    input  logic [4:0]          pixel_scale,
    input  logic [11:0]         window_left,
    input  logic [11:0]         window_right,
    input  logic [11:0]         window_top,
    input  logic [11:0]         window_bottom,
    output logic                done,
    output pvp_pkg::result_t    result
);

    localparam int unsigned QW = pvp_pkg::NumW + 1;
    localparam int unsigned SW = QW + 6;

    // stage a: signed quotients
    logic                  va_reg;
    logic                  fa_reg;
    logic signed [QW-1:0]  qx_reg;
    logic signed [QW-1:0]  qy_reg;
    logic signed [QW-1:0]  qx_next;
    logic signed [QW-1:0]  qy_next;
    // stage b: scaled and centred
    logic                  vb_reg;
    logic                  fb_reg;
    logic signed [SW-1:0]  sx_reg;
    logic signed [SW-1:0]  sy_reg;
    logic signed [SW-1:0]  sx_next;
    logic signed [SW-1:0]  sy_next;
    // stage c: saturated output
    logic                  vc_reg;
    pvp_pkg::result_t      res_reg;
    pvp_pkg::result_t      res_next;

    function automatic logic signed [31:0] sat32(input logic signed [SW-1:0] v);
        logic signed [SW-1:0] hi;
        logic signed [SW-1:0] lo;
        hi = SW'(signed'(33'sh0_7FFF_FFFF));
        lo = SW'(signed'(33'sh1_8000_0000));
        if (v > hi)
            sat32 = 32'sh7FFF_FFFF;
        else if (v < lo)
            sat32 = 32'sh8000_0000;
        else
            sat32 = v[31:0];
    endfunction

    always_comb
    begin
        qx_next = cell_in.neg_x ? -signed'({1'b0, cell_in.num_x})
                                :  signed'({1'b0, cell_in.num_x});
        qy_next = cell_in.neg_y ? -signed'({1'b0, cell_in.num_y})
                                :  signed'({1'b0, cell_in.num_y});
        sx_next = SW'(qx_reg) * signed'({1'b0, pixel_scale})
                + signed'(SW'({1'b0, mid_x}));
        sy_next = SW'(qy_reg) * signed'({1'b0, pixel_scale})
                + signed'(SW'({1'b0, mid_y}));
        res_next = '0;
        if (fb_reg)
        begin
            res_next.pix_x = sat32(sx_reg);
            res_next.pix_y = sat32(sy_reg);
            res_next.in_front = 1'b1;
            res_next.on_screen =
                (res_next.pix_x >= signed'({20'd0, window_left}))   &&
                (res_next.pix_x <= signed'({20'd0, window_right}))  &&
                (res_next.pix_y >= signed'({20'd0, window_top}))    &&
                (res_next.pix_y <= signed'({20'd0, window_bottom}));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
        end
        else
        begin
            va_reg <= cell_in.valid;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        fa_reg  <= cell_in.in_front;
        qx_reg  <= qx_next;
        qy_reg  <= qy_next;
        fb_reg  <= fa_reg;
        sx_reg  <= sx_next;
        sy_reg  <= sy_next;
        res_reg <= res_next;
    end

    assign done   = vc_reg;
    assign result = res_reg;

    // a hidden vertex never reports on screen
    a_hidden_off: assert property (@(posedge clk) disable iff (!rst_n)
        done && !result.in_front |-> !result.on_screen && result.pix_x == 32'sd0)
        else $error("hidden vertex with nonzero result");
    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        va_reg |-> ##2 done)
        else $error("finish stage lost an item");
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(va_reg, 2))
        else $error("finish stage invented an item");

endmodule

// ===== rtl/core/perspective_vertex_project_top.sv =====
// ----------------------------------------------------------------------------
// perspective_vertex_project_top
// perspective divide of camera-space vertices into screen pixels
// ----------------------------------------------------------------------------
// One vertex may be started in every cycle and each gives exactly one result,
// shown with done high for one cycle. Each vertex is registered at the entry,
// then passes the chain of division cells, one quotient bit per cell, and the
// sign, scale and saturation stages. busy is always low: the receiver cannot
// stall, so results must be taken as they appear. Register writes take effect
// on the next edge and should only be made while no item is in flight.
module perspective_vertex_project_top #(
    parameter int unsigned FOCAL_SCALE = pvp_pkg::FOCAL_SCALE_DEF
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  pvp_pkg::vertex_t                 vertex,
    output logic                             done,
    output pvp_pkg::result_t                 result,
    input  logic                             cfg_we,
    input  logic [pvp_pkg::CfgIdxW-1:0]      cfg_index,
    input  logic [pvp_pkg::CfgDataW-1:0]     cfg_data
);

    localparam int unsigned NCELLS = pvp_pkg::NumW;

    logic [11:0] mid_x_reg;
    logic [11:0] mid_y_reg;
    logic [4:0]  pixel_scale_reg;
    logic [11:0] window_left_reg;
    logic [11:0] window_right_reg;
    logic [11:0] window_top_reg;
    logic [11:0] window_bottom_reg;

    pvp_pkg::div_cell_t chain [NCELLS+1];
    pvp_pkg::div_cell_t head_reg;
    pvp_pkg::div_cell_t head_next;

    logic        [31:0] mag_x;
    logic        [31:0] mag_y;
    logic [63:0] prod_x;
    logic [63:0] prod_y;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mid_x_reg         <= 12'd640;
            mid_y_reg         <= 12'd256;
            pixel_scale_reg   <= 5'd4;
            window_left_reg   <= 12'd0;
            window_right_reg  <= 12'd1279;
            window_top_reg    <= 12'd0;
            window_bottom_reg <= 12'd1023;
        end
        else if (cfg_we)
        begin
            case (pvp_pkg::cfg_idx_t'(cfg_index))
                pvp_pkg::REG_MID_X:         mid_x_reg         <= cfg_data;
                pvp_pkg::REG_MID_Y:         mid_y_reg         <= cfg_data;
                pvp_pkg::REG_PIXEL_SCALE:   pixel_scale_reg   <= cfg_data[4:0];
                pvp_pkg::REG_WINDOW_LEFT:   window_left_reg   <= cfg_data;
                pvp_pkg::REG_WINDOW_RIGHT:  window_right_reg  <= cfg_data;
                pvp_pkg::REG_WINDOW_TOP:    window_top_reg    <= cfg_data;
                pvp_pkg::REG_WINDOW_BOTTOM: window_bottom_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // entry: magnitudes, focal scale product and sign bookkeeping
    always_comb
    begin
        mag_x  = vertex.pos_x[31] ? 32'(-vertex.pos_x) : 32'(vertex.pos_x);
        mag_y  = vertex.pos_y[31] ? 32'(-vertex.pos_y) : 32'(vertex.pos_y);
        prod_x = 64'(mag_x) * 64'(FOCAL_SCALE);
        prod_y = 64'(mag_y) * 64'(FOCAL_SCALE);
        head_next          = '0;
        head_next.valid    = start;
        head_next.in_front = !vertex.pos_z[31] && (vertex.pos_z != 32'sd0);
        // hidden vertices divide zero by one, the result is masked at the end
        if (head_next.in_front)
        begin
            head_next.num_x = prod_x[pvp_pkg::NumW-1:0];
            head_next.num_y = prod_y[pvp_pkg::NumW-1:0];
            head_next.den   = vertex.pos_z[pvp_pkg::DenW-1:0];
            head_next.neg_x = vertex.pos_x[31];
            head_next.neg_y = vertex.pos_y[31];
        end
        else
        begin
            head_next.den = pvp_pkg::DenW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
        end
        else
        begin
            head_reg <= head_next;
        end
    end

    assign chain[0] = head_reg;

    for (genvar i = 0; i < NCELLS; i++)
    begin : g_cell
        pvp_div_cell u_cell
        (
            .clk     (clk),
            .rst_n   (rst_n),
            .cell_in (chain[i]),
            .cell_out(chain[i+1])
        );
    end

    pvp_finish u_finish
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cell_in      (chain[NCELLS]),
        .mid_x        (mid_x_reg),
        .mid_y        (mid_y_reg),
        .pixel_scale  (pixel_scale_reg),
        .window_left  (window_left_reg),
        .window_right (window_right_reg),
        .window_top   (window_top_reg),
        .window_bottom(window_bottom_reg),
        .done         (done),
        .result       (result)
    );

    assign busy = 1'b0;

    a_not_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised");
    a_chain_exit: assert property (@(posedge clk) disable iff (!rst_n)
        head_reg.valid |-> ##(NCELLS) chain[NCELLS].valid)
        else $error("division chain dropped an item");
    a_start_done: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##(NCELLS + 4) done)
        else $error("started item never finished");

endmodule
